FILE: hw/rtl/kch_pkg.sv
// ----------------------------------------------------------------------------
// kch_pkg
// Shared types and constants for the keyed count hash table.
// ----------------------------------------------------------------------------
package kch_pkg;

   localparam int unsigned DEF_BUCKETS = 4096;
   localparam int unsigned DEF_WAYS    = 4;

   localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
   localparam int unsigned MIX_SHIFT = 33;

   localparam logic [30:0] COUNT_MAX = 31'h7fffffff;
   localparam logic [47:0] TOTAL_MAX = 48'hffffffffffff;

   typedef enum logic [2:0] {
      STAT_UPDATED = 3'd0,
      STAT_INSERTED = 3'd1,
      STAT_REMOVED = 3'd2,
      STAT_ABSENT = 3'd3,
      STAT_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic [63:0]        item_key;
      logic signed [31:0] count_delta;
   } req_type;

   typedef struct packed {
      status_type  update_status;
      logic [30:0] key_count;
      logic [47:0] total_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [30:0] count;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_READ,
      S_LOOK,
      S_OUT
   } state_type;

endpackage

FILE: hw/rtl/keyed_count_hash_table.sv
// ----------------------------------------------------------------------------
// keyed_count_hash_table
// Counting hash table: fmix64-hashed buckets of WAYS entries, saturating counts.
// ----------------------------------------------------------------------------
// After reset the block sweeps all BUCKETS buckets (4096 by default) of the
// bucket memory, one bucket per cycle, before req_ready first rises. A beat
// then goes from acceptance to rsp_valid through the hash, which runs two
// 64-bit multiplies through one shared 32x32 multiplier, then a bucket read,
// a compare-and-update step and the result register. A new beat is taken
// once the previous one has reached the result register. BUCKETS must be a
// power of two; the bucket is the low bits of the hash.
module keyed_count_hash_table
   import kch_pkg::*;
#(
   parameter int unsigned BUCKETS = DEF_BUCKETS,
   parameter int unsigned WAYS    = DEF_WAYS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int unsigned BKT_W = $clog2(BUCKETS);
   localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   state_type            state_ff, state_in;
   logic [63:0]          seed_ff, seed_in;
   logic [63:0]          key_ff, key_in;
   logic signed [31:0]   delta_ff, delta_in;
   logic [BKT_W-1:0]     bkt_ff, bkt_in;
   logic [47:0]          total_ff, total_in;
   rsp_type              pend_ff, pend_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 tbl_ready;
   logic                 mix_start, mix_done;
   logic [63:0]          mix_out;
   logic                 rd_en, wr_en;
   entry_type [WAYS-1:0] row, wr_row;

   logic [WAYS-1:0]      hit_vec, free_vec;
   logic [WAY_W-1:0]     hit_idx, free_idx;
   logic                 hit, has_free;
   logic [30:0]          old_cnt, new_cnt;
   logic signed [32:0]   sum, diff;
   logic signed [49:0]   tsum;

   kch_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .din   (req_data.item_key + seed_ff),
      .done  (mix_done),
      .dout  (mix_out)
   );

   kch_table #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ready   (tbl_ready),
      .rd_en   (rd_en),
      .rd_addr (bkt_ff),
      .rd_data (row),
      .wr_en   (wr_en),
      .wr_addr (bkt_ff),
      .wr_data (wr_row)
   );

   // lowest matching way and lowest free way
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w]  = row[w].valid && (row[w].key == key_ff);
         free_vec[w] = ~row[w].valid;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_idx = WAY_W'(w);
         if (free_vec[w]) free_idx = WAY_W'(w);
      end
      hit      = |hit_vec;
      has_free = |free_vec;
      old_cnt  = row[hit_idx].count;
      sum      = $signed({2'b00, old_cnt}) + $signed({delta_ff[31], delta_ff});
      new_cnt  = (!sum[32] && sum[31]) ? COUNT_MAX : sum[30:0];
   end

   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      key_in       = key_ff;
      delta_in     = delta_ff;
      bkt_in       = bkt_ff;
      total_in     = total_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = tbl_ready && (state_ff == S_IDLE);
      mix_start    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_row       = row;
      diff         = '0;
      tsum         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               key_in    = req_data.item_key;
               delta_in  = req_data.count_delta;
               mix_start = 1'b1;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            if (mix_done) begin
               bkt_in   = mix_out[BKT_W-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_LOOK;
         end
         S_LOOK: begin
            pend_in.key_count = '0;
            if (hit) begin
               wr_en = 1'b1;
               if (sum[32] || sum == '0) begin
                  wr_row[hit_idx].valid = 1'b0;
                  diff = -$signed({2'b00, old_cnt});
                  pend_in.update_status = STAT_REMOVED;
               end else begin
                  wr_row[hit_idx].count = new_cnt;
                  diff = $signed({2'b00, new_cnt}) - $signed({2'b00, old_cnt});
                  pend_in.update_status = STAT_UPDATED;
                  pend_in.key_count = new_cnt;
               end
            end else if (delta_ff[31] || delta_ff == '0) begin
               pend_in.update_status = STAT_ABSENT;
            end else if (!has_free) begin
               pend_in.update_status = STAT_FULL;
            end else begin
               wr_en = 1'b1;
               wr_row[free_idx].valid = 1'b1;
               wr_row[free_idx].key   = key_ff;
               wr_row[free_idx].count = delta_ff[30:0];
               diff = $signed({1'b0, delta_ff});
               pend_in.update_status = STAT_INSERTED;
               pend_in.key_count = delta_ff[30:0];
            end
            tsum = $signed({2'b00, total_ff}) + 50'(diff);
            if (tsum[49]) total_in = '0;
            else if (tsum[48]) total_in = TOTAL_MAX;
            else total_in = tsum[47:0];
            pend_in.total_count = total_in;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff   <= key_in;
      delta_ff <= delta_in;
      bkt_ff   <= bkt_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/kch_mix.sv
// ----------------------------------------------------------------------------
// kch_mix
// 64-bit finalizer mix on one shared 32x32 multiplier, nine steps per value.
// ----------------------------------------------------------------------------
module kch_mix
   import kch_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] din,
   output logic        done,
   output logic [63:0] dout
);

   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mul_c;
   logic [31:0] op_x, op_y;
   logic [63:0] prod;
   logic [63:0] k_xs;

   // low 64 bits of k*c = kL*cL + ((kH*cL + kL*cH) << 32)
   always_comb begin
      mul_c = (step_ff < 4'd4) ? MIX_MUL_A : MIX_MUL_B;
      op_x  = (step_ff == 4'd2 || step_ff == 4'd6) ? k_ff[63:32] : k_ff[31:0];
      op_y  = (step_ff == 4'd3 || step_ff == 4'd7) ? mul_c[63:32] : mul_c[31:0];
      prod  = 64'(op_x) * 64'(op_y);
      k_xs  = k_ff ^ (k_ff >> MIX_SHIFT);
   end

   always_comb begin
      k_in    = k_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         k_in    = din;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         unique case (step_ff)
            4'd0, 4'd4: k_in = k_xs;
            4'd1, 4'd5: acc_in = prod;
            4'd2, 4'd6: acc_in = acc_ff + {prod[31:0], 32'd0};
            4'd3, 4'd7: k_in = acc_ff + {prod[31:0], 32'd0};
            4'd8: begin
               k_in    = k_xs;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      k_ff   <= k_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign dout = k_ff;

endmodule

FILE: hw/rtl/kch_table.sv
// ----------------------------------------------------------------------------
// kch_table
// Bucket memory, one row of all ways per bucket, with a clear pass at reset.
// ----------------------------------------------------------------------------
module kch_table
   import kch_pkg::*;
#(
   parameter int unsigned BUCKETS = DEF_BUCKETS,
   parameter int unsigned WAYS    = DEF_WAYS,
   localparam int unsigned BKT_W  = $clog2(BUCKETS)
)
(
   input  logic                  clock,
   input  logic                  reset,
   output logic                  ready,
   input  logic                  rd_en,
   input  logic [BKT_W-1:0]      rd_addr,
   output entry_type [WAYS-1:0]  rd_data,
   input  logic                  wr_en,
   input  logic [BKT_W-1:0]      wr_addr,
   input  entry_type [WAYS-1:0]  wr_data
);

   entry_type [WAYS-1:0] mem [BUCKETS];
   entry_type [WAYS-1:0] rd_data_ff;
   logic                 clr_ff, clr_in;
   logic [BKT_W-1:0]     clr_idx_ff, clr_idx_in;
   logic                 we;
   logic [BKT_W-1:0]     wa;
   entry_type [WAYS-1:0] wd;

   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == BKT_W'(BUCKETS - 1)) clr_in = 1'b0;
      end
      we = clr_ff | wr_en;
      wa = clr_ff ? clr_idx_ff : wr_addr;
      wd = clr_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign ready   = ~clr_ff;
   assign rd_data = rd_data_ff;

endmodule
